// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SAMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SAMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sams_pkg.sv =====
// shared types for the sort and singleton marking block
// no dependencies
package sams_pkg;

  typedef logic signed [31:0] data_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

// ===== rtl/core/sams_cell.sv =====
// one cell of the sorting chain: holds one element, compares it with the
// broadcast item and shifts toward its neighbors; uses sams_pkg
module sams_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sams_pkg::cell_ctl_t ctl,
  input  sams_pkg::data_t     new_value,
  input  sams_pkg::data_t     left_value,
  input  logic                left_valid,
  input  logic                left_lt,
  input  sams_pkg::data_t     right_value,
  input  logic                right_valid,
  output sams_pkg::data_t     value,
  output logic                valid,
  output logic                lt
);

  sams_pkg::data_t value_r, value_nxt;
  logic            valid_r, valid_nxt;

  assign lt = !valid_r || (new_value < value_r);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.ins) begin
      if (left_lt) begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end else if (lt) begin
        value_nxt = new_value;
        valid_nxt = 1'b1;
      end
    end else if (ctl.pop) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

// ===== rtl/core/sort_and_mark_singletons.sv =====
// top level of the sort and singleton marking block
// uses sams_pkg and a chain of sams_cell instances
//
// Items are accepted one per cycle while a set is loading; each item is placed
// in sorted position in the same cycle by a chain of DEPTH compare-and-shift
// cells. Items beyond DEPTH are dropped and flagged on every result of the set.
// After the item marked final, in_ready stays low while the set is emitted,
// smallest first, one result per cycle while out_ready does not stall, from
// the head of the chain through an output register. The state register first
// switches to emit, then the head goes into the output register. Loading of
// the next set may start while the last result still waits to be taken.
module sort_and_mark_singletons #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  input  logic        in_final_element,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sorted_value,
  output logic        out_is_singleton,
  output logic        out_end_of_run,
  output logic        out_overflowed
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic            state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic            first_r, first_nxt;
  sams_pkg::data_t prev_r, prev_nxt;

  logic            out_valid_r, out_valid_nxt;
  sams_pkg::data_t out_value_r, out_value_nxt;
  logic            out_single_r, out_single_nxt;
  logic            out_end_r, out_end_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  sams_pkg::cell_ctl_t ctl;
  sams_pkg::data_t     cell_value [DEPTH];
  logic                cell_valid [DEPTH];
  logic                cell_lt    [DEPTH];

  logic in_acc, full, adv, last_one;

  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign full     = (count_r == CntW'(DEPTH));
  assign adv      = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign last_one = !cell_valid[1];

  assign ctl.ins = in_acc && !full;
  assign ctl.pop = adv;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sams_pkg::data_t lv, rv;
    logic            lvld, llt, rvld;
    if (i == 0) begin : g_head
      assign lv   = '0;
      assign lvld = 1'b0;
      assign llt  = 1'b0;
    end else begin : g_mid
      assign lv   = cell_value[i-1];
      assign lvld = cell_valid[i-1];
      assign llt  = cell_lt[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rv   = '0;
      assign rvld = 1'b0;
    end else begin : g_body
      assign rv   = cell_value[i+1];
      assign rvld = cell_valid[i+1];
    end
    sams_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_value   (sams_pkg::data_t'(in_value)),
      .left_value  (lv),
      .left_valid  (lvld),
      .left_lt     (llt),
      .right_value (rv),
      .right_valid (rvld),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .lt          (cell_lt[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    first_nxt      = first_r;
    prev_nxt       = prev_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_single_nxt = out_single_r;
    out_end_nxt    = out_end_r;
    out_ovf_nxt    = out_ovf_r;
    if (in_acc) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CntW'(1);
      end
      if (in_final_element) begin
        state_nxt = ST_EMIT;
      end
    end
    if (adv) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = cell_value[0];
      out_single_nxt = (first_r || (prev_r != cell_value[0])) &&
                       (last_one || (cell_value[1] != cell_value[0]));
      out_end_nxt    = last_one;
      out_ovf_nxt    = ovf_r;
      prev_nxt       = cell_value[0];
      first_nxt      = 1'b0;
      if (last_one) begin
        state_nxt = ST_LOAD;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        first_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prev_r       <= prev_nxt;
    out_value_r  <= out_value_nxt;
    out_single_r <= out_single_nxt;
    out_end_r    <= out_end_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_is_singleton = out_single_r;
  assign out_end_of_run   = out_end_r;
  assign out_overflowed   = out_ovf_r;

endmodule

// ===== rtl/core/sams_checker.sv =====
// port-level checks for sort_and_mark_singletons, bound to the top level
// uses assert_macros.svh
`include "assert_macros.svh"

module sams_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_final_element,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sorted_value,
  input logic        out_end_of_run,
  input logic        out_overflowed
);

  `SAMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_sorted_value) && $stable(out_overflowed),
    "result changed while stalled")
  `SAMS_ASSERT_NEXT(a_final_closes, clk, rst_n, in_valid && in_ready && in_final_element,
    !in_ready, "input still taken after final item")
  `SAMS_ASSERT_NOW(a_no_load_mid_run, clk, rst_n, out_valid && !out_end_of_run,
    !in_ready, "input taken while a set is being emitted")
  `SAMS_ASSERT_NEXT(a_ascending, clk, rst_n, out_valid && out_ready && !out_end_of_run,
    out_valid && ($signed(out_sorted_value) >= $signed($past(out_sorted_value))),
    "results not in ascending order")

endmodule

bind sort_and_mark_singletons sams_checker u_sams_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_final_element (in_final_element),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sorted_value (out_sorted_value),
  .out_end_of_run   (out_end_of_run),
  .out_overflowed   (out_overflowed)
);
